// ===== hw/rtl/psu_pkg.sv =====
// Shared types and constants for the pendulum swing-up step block.
// No dependencies; used by the CORDIC unit and the top level.
`default_nettype none
package psu_pkg;

  localparam int Q30W = 34;
  localparam logic signed [Q30W-1:0] Q30_PI = 34'sd3373259426;
  localparam logic signed [Q30W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [Q30W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam int ATAN_COUNT = 24;

  typedef logic signed [Q30W-1:0] q30_t;

  function automatic q30_t atan_lookup(input logic [4:0] idx);
    q30_t r;
    unique case (idx)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Configuration register indexes.
  localparam logic [2:0] REG_TIME_STEP    = 3'd0;
  localparam logic [2:0] REG_GRAVITY_GAIN = 3'd1;
  localparam logic [2:0] REG_TORQUE_MAX   = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd3;
  localparam logic [2:0] REG_UPRIGHT_BAND = 3'd4;
  localparam logic [2:0] REG_OVER_MODE    = 3'd5;
  localparam logic [2:0] REG_OVER_LIMIT   = 3'd6;

  localparam logic OP_RESET = 1'b0;

endpackage
`default_nettype wire

// ===== hw/rtl/pendulum_swing_up_step_top.sv =====
// Pendulum swing-up environment step, top level with sequencer and datapath.
// Depends on psu_pkg and psu_cordic.
//
// Usage: an item (operation, action_index, start_angle) is taken on the in_
// channel when in_valid is high and in_stall is low. Every item gives exactly
// one result on the out_ channel, held until out_stall is low.
// A reset item passes once through the shared wrap unit. A step item runs the
// shared CORDIC twice (sine of the old angle and cosine of the new one), the
// wrap unit twice (new angle and angle change) and six further states (MUL1,
// MUL2, VEL, MUL3, TURN and OUT).
// The block takes one item at a time; in_stall is high while an item is at
// work or its result is not yet taken. A stalled result holds its fields.
// Synchronous reset (rst_n low) loads the default register values and zeroes
// the pendulum state. Configuration writes (cfg_we, cfg_index, cfg_data) are
// taken at any time but are only meant while the block is idle.
`default_nettype none
module pendulum_swing_up_step_top import psu_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int TRIG_STEPS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [2:0]        cfg_index,
  input  wire  [23:0]       cfg_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_operation,
  input  wire  [1:0]        in_action_index,
  input  wire signed [18:0] in_start_angle,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [18:0] out_angle_out,
  output logic signed [24:0] out_velocity_out,
  output logic signed [17:0] out_reward_out,
  output logic              out_terminal,
  output logic [15:0]       out_upright_steps
);
  localparam int W = 40;
  localparam int MW = 25;
  localparam int TW = FRAC_BITS + 4;
  typedef logic signed [W-1:0] acc_t;

  localparam logic [3:0] S_IDLE = 4'd0, S_RST = 4'd1, S_SIN = 4'd2, S_MUL1 = 4'd3,
    S_MUL2 = 4'd4, S_VEL = 4'd5, S_MUL3 = 4'd6, S_WRAP = 4'd7, S_DIFF = 4'd8,
    S_TURN = 4'd9, S_COS = 4'd10, S_OUT = 4'd11, S_WAIT = 4'd12;

  localparam acc_t PI_Q = acc_t'((64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS)))
                                 >>> (30 - FRAC_BITS));
  localparam acc_t TWO_PI = 2 * PI_Q;
  localparam acc_t FIVE_PI = 5 * PI_Q;
  localparam acc_t ONE_Q = acc_t'(1) <<< FRAC_BITS;
  localparam logic [3:0] WRAP_STEPS = 4'd8;

  logic [16:0] time_step_r;
  logic [23:0] gravity_r, torque_r, speed_r;
  logic [17:0] band_r;
  logic        mode_r;
  logic [15:0] olimit_r;

  logic [3:0]  st_r;
  acc_t angle_r, vel_r, prev_r, turn_r, t_r, a_r;
  logic over_r;
  logic [15:0] osteps_r, usteps_r;
  logic [1:0]  act_r;
  logic cstart;
  logic cdone;
  logic signed [FRAC_BITS+1:0] csin, ccos;
  logic signed [FRAC_BITS+1:0] ccos_r;
  logic signed [TW-1:0] cang;

  // Shared multiplier with round half up (floor shift).
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] mul_full;
  acc_t mul_p;
  always_comb begin
    mul_full = mul_a * mul_b + (2*MW)'(64'sd1 <<< (FRAC_BITS - 1));
    mul_p = acc_t'(mul_full >>> FRAC_BITS);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      S_MUL1: begin mul_a = MW'(time_step_r); mul_b = vel_r[MW-1:0]; end
      S_MUL2: begin mul_a = MW'(gravity_r); mul_b = MW'(csin); end
      S_MUL3: begin mul_a = t_r[MW-1:0]; mul_b = MW'(time_step_r); end
      default: ;
    endcase
  end

  assign cang = TW'(st_r == S_SIN ? angle_r : t_r);

  psu_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cang),
    .done(cdone), .sin_q(csin), .cos_q(ccos)
  );

  logic started_r;
  assign cstart = (st_r == S_SIN || st_r == S_COS) && !started_r;
  assign in_stall = (st_r != S_IDLE);

  // Wrap unit: reduces t_r + pi modulo 2*pi by adding or subtracting 2*pi
  // scaled by 64 down to 1, one scale per cycle, then a last fix-up pass.
  // The largest angle advance is well below 128 turns.
  acc_t wr_r, wt_r, wr_step, wrap_out;
  logic [3:0] wn_r;
  logic wbusy_r, wdone_r, wstart;

  assign wstart = (st_r == S_RST || st_r == S_WRAP || st_r == S_DIFF) && !started_r;

  always_comb begin
    if (wr_r >= wt_r) wr_step = wr_r - wt_r;
    else if (wr_r < 0) wr_step = wr_r + wt_r;
    else wr_step = wr_r;
  end
  assign wrap_out = wr_r - PI_Q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbusy_r <= 1'b0;
      wdone_r <= 1'b0;
    end else begin
      wdone_r <= 1'b0;
      if (wstart) begin
        wbusy_r <= 1'b1;
        wr_r <= t_r + PI_Q;
        wt_r <= TWO_PI <<< 6;
        wn_r <= WRAP_STEPS;
      end else if (wbusy_r) begin
        wr_r <= wr_step;
        if (wn_r > 4'd2) wt_r <= wt_r >>> 1;
        wn_r <= wn_r - 4'd1;
        if (wn_r == 4'd1) begin
          wbusy_r <= 1'b0;
          wdone_r <= 1'b1;
        end
      end
    end
  end

  acc_t absa;
  assign absa = wrap_out < 0 ? -wrap_out : wrap_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= 17'd655;
      gravity_r <= 24'd642253;
      torque_r <= 24'd131072;
      speed_r <= 24'd5147188;
      band_r <= 18'd51472;
      mode_r <= 1'b0;
      olimit_r <= 16'd100;
      st_r <= S_IDLE;
      angle_r <= '0; vel_r <= '0; prev_r <= '0; turn_r <= '0;
      over_r <= 1'b0; osteps_r <= '0; usteps_r <= '0;
      out_valid <= 1'b0;
      started_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:    time_step_r <= cfg_data[16:0];
          REG_GRAVITY_GAIN: gravity_r <= cfg_data;
          REG_TORQUE_MAX:   torque_r <= cfg_data;
          REG_SPEED_LIMIT:  speed_r <= cfg_data;
          REG_UPRIGHT_BAND: band_r <= cfg_data[17:0];
          REG_OVER_MODE:    mode_r <= cfg_data[0];
          REG_OVER_LIMIT:   olimit_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          act_r <= in_action_index;
          t_r <= acc_t'(in_start_angle);
          started_r <= 1'b0;
          st_r <= (in_operation == OP_RESET) ? S_RST : S_SIN;
        end
        S_RST: begin
          if (wdone_r) begin
            angle_r <= wrap_out; prev_r <= wrap_out; turn_r <= wrap_out;
            vel_r <= '0; over_r <= 1'b0; osteps_r <= '0; usteps_r <= '0;
            out_angle_out <= wrap_out[18:0];
            out_velocity_out <= '0;
            out_reward_out <= '0;
            out_terminal <= 1'b0;
            out_upright_steps <= '0;
            out_valid <= 1'b1;
            started_r <= 1'b0;
            st_r <= S_WAIT;
          end else begin
            started_r <= 1'b1;
          end
        end
        S_SIN: begin
          if (cdone) begin started_r <= 1'b0; st_r <= S_MUL1; end
          else started_r <= 1'b1;
        end
        S_MUL1: begin
          a_r <= (act_r == 2'd0) ? -acc_t'(torque_r) :
                 (act_r == 2'd2) ? acc_t'(torque_r) : '0;
          t_r <= mul_p;
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          a_r <= a_r + mul_p - t_r + vel_r;
          st_r <= S_VEL;
        end
        S_VEL: begin
          if (a_r > acc_t'(speed_r)) t_r <= acc_t'(speed_r);
          else if (a_r < -acc_t'(speed_r)) t_r <= -acc_t'(speed_r);
          else t_r <= a_r;
          st_r <= S_MUL3;
        end
        S_MUL3: begin
          vel_r <= t_r;
          t_r <= angle_r + mul_p;
          st_r <= S_WRAP;
        end
        S_WRAP: begin
          if (wdone_r) begin
            angle_r <= wrap_out;
            if (absa > acc_t'(band_r)) usteps_r <= '0;
            else if (usteps_r != 16'hFFFF) usteps_r <= usteps_r + 16'd1;
            t_r <= wrap_out - prev_r;
            started_r <= 1'b0;
            st_r <= S_DIFF;
          end else begin
            started_r <= 1'b1;
          end
        end
        S_DIFF: begin
          if (wdone_r) begin
            a_r <= (wrap_out == -PI_Q) ? PI_Q : wrap_out;
            t_r <= angle_r;
            prev_r <= angle_r;
            started_r <= 1'b0;
            st_r <= S_TURN;
          end else begin
            started_r <= 1'b1;
          end
        end
        S_TURN: begin
          acc_t s, as;
          logic ov;
          s = turn_r + a_r;
          if (s > acc_t'(32'sh7FFFFFFF)) s = acc_t'(32'sh7FFFFFFF);
          if (s < -acc_t'(64'sh80000000)) s = -acc_t'(64'sh80000000);
          as = s < 0 ? -s : s;
          ov = over_r || (as > FIVE_PI);
          turn_r <= s;
          over_r <= ov;
          if (ov && osteps_r != 16'hFFFF) osteps_r <= osteps_r + 16'd1;
          st_r <= S_COS;
        end
        S_COS: begin
          if (cdone) begin started_r <= 1'b0; st_r <= S_OUT; end
          else started_r <= 1'b1;
        end
        S_OUT: begin
          out_angle_out <= angle_r[18:0];
          out_velocity_out <= vel_r[24:0];
          out_reward_out <= (mode_r && over_r) ? -ONE_Q[17:0] : 18'(ccos_r);
          out_terminal <= mode_r && over_r && (osteps_r > olimit_r);
          out_upright_steps <= usteps_r;
          out_valid <= 1'b1;
          st_r <= S_WAIT;
        end
        S_WAIT: if (!out_stall) begin
          out_valid <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Cosine captured when the unit reports done.
  always_ff @(posedge clk) begin
    if (cdone) ccos_r <= ccos;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/psu_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q4.30 inside.
// Depends on psu_pkg for the arctangent table and the gain constant.
`default_nettype none
module psu_cordic import psu_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int TRIG_STEPS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire signed [FRAC_BITS+3:0]   angle,
  output logic                         done,
  output logic signed [FRAC_BITS+1:0]  sin_q,
  output logic signed [FRAC_BITS+1:0]  cos_q
);
  localparam int STEPS = (TRIG_STEPS < ATAN_COUNT) ? TRIG_STEPS : ATAN_COUNT;
  localparam int SH = 30 - FRAC_BITS;
  localparam int QW = FRAC_BITS + 2;

  q30_t x_r, y_r, z_r;
  logic flip_r, busy_r;
  logic [4:0] i_r;

  q30_t z_in, z_adj, x_sh, y_sh;
  logic flip_in;

  always_comb begin
    z_in = q30_t'(angle) <<< SH;
    flip_in = 1'b0;
    z_adj = z_in;
    if (z_in > Q30_HALF_PI) begin
      z_adj = z_in - Q30_PI;
      flip_in = 1'b1;
    end else if (z_in < -Q30_HALF_PI) begin
      z_adj = z_in + Q30_PI;
      flip_in = 1'b1;
    end
    x_sh = x_r >>> i_r;
    y_sh = y_r >>> i_r;
  end

  function automatic logic signed [QW-1:0] to_q(input q30_t v, input logic neg);
    q30_t t, r;
    q30_t one;
    t = neg ? -v : v;
    one = q30_t'(1) <<< FRAC_BITS;
    r = (t + (q30_t'(1) <<< (SH - 1))) >>> SH;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[QW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r <= '0;
        x_r <= CORDIC_INV_GAIN;
        y_r <= '0;
        z_r <= z_adj;
        flip_r <= flip_in;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_lookup(i_r);
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_lookup(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Output conversion is valid in the cycle done is high.
  assign sin_q = to_q(y_r, flip_r);
  assign cos_q = to_q(x_r, flip_r);
endmodule
`default_nettype wire

// ===== sim/pendulum_swing_up_step_top_tb.sv =====
// Self-checking testbench for pendulum_swing_up_step_top: directed, register-extreme,
// over-rotation, back-pressure and randomized tests against an in-bench fixed-point
// predictor. Depends on psu_pkg and the block's RTL.
`timescale 1ns / 100ps
module pendulum_swing_up_step_top_tb;
  import psu_pkg::*;

  localparam logic OP_STEP = 1'b1;
  localparam logic [1:0] ACT_NEG = 2'd0, ACT_ZERO = 2'd1, ACT_POS = 2'd2, ACT_SPARE = 2'd3;
  localparam int FRAC = 16;
  localparam int ITERS = 16;
  localparam longint ONE = 65536;

  typedef struct packed {
    logic [18:0] angle;
    logic [24:0] velocity;
    logic [17:0] reward;
    logic        terminal;
    logic [15:0] upright;
  } swing_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [1:0]  in_action_index = '0;
  logic signed [18:0] in_start_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [18:0] out_angle_out;
  logic signed [24:0] out_velocity_out;
  logic signed [17:0] out_reward_out;
  logic        out_terminal;
  logic [15:0] out_upright_steps;

  pendulum_swing_up_step_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_action_index(in_action_index), .in_start_angle(in_start_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle_out(out_angle_out), .out_velocity_out(out_velocity_out),
    .out_reward_out(out_reward_out), .out_terminal(out_terminal),
    .out_upright_steps(out_upright_steps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and pendulum state of the predictor.
  longint dt_q, grav_q, torque_q, vmax_q, band_q, spin_mode, spin_limit;
  longint ang, vel, last_ang, spin_sum;
  bit     spun;
  longint spun_steps, up_count;

  swing_result_t pending_results[$];
  int  fail_count = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  terminal_seen = 0;
  int  hold_len = 0;
  bit  calm = 1'b0;

  function automatic longint pi_q();
    return (longint'(Q30_PI) + (64'sd1 <<< 13)) >>> 14;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint wrap_pi(longint a);
    longint p, r;
    p = pi_q();
    r = (a + p) % (2 * p);
    if (r < 0) r += 2 * p;
    return r - p;
  endfunction

  function automatic longint q30_to_q(longint v);
    longint r;
    r = (v + (64'sd1 <<< 13)) >>> 14;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r;
  endfunction

  function automatic void sin_cos(input longint a, output longint s, output longint c);
    longint z, x, y, nx;
    bit flip;
    z = a * 16384;
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > longint'(Q30_HALF_PI)) begin
      z -= longint'(Q30_PI);
      flip = 1'b1;
    end else if (z < -longint'(Q30_HALF_PI)) begin
      z += longint'(Q30_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_lookup(i[4:0]));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_lookup(i[4:0]));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = q30_to_q(y);
    c = q30_to_q(x);
  endfunction

  task automatic restore_defaults();
    dt_q = 655; grav_q = 642253; torque_q = 131072; vmax_q = 5147188;
    band_q = 51472; spin_mode = 0; spin_limit = 100;
    ang = 0; vel = 0; last_ang = 0; spin_sum = 0;
    spun = 1'b0; spun_steps = 0; up_count = 0;
  endtask

  function automatic swing_result_t predict_swing(logic op, logic [1:0] act,
                                                  logic signed [18:0] start);
    swing_result_t r;
    longint s, c, tq, v, th, d, reward;
    bit term;
    reward = 0;
    term = 1'b0;
    if (op == OP_RESET) begin
      th = wrap_pi(longint'(start));
      ang = th; vel = 0; last_ang = th; spin_sum = th;
      spun = 1'b0; spun_steps = 0; up_count = 0;
    end else begin
      tq = (act == ACT_NEG) ? -torque_q : (act == ACT_POS) ? torque_q : 0;
      sin_cos(ang, s, c);
      v = vel - fmul(dt_q, vel) + fmul(grav_q, s) + tq;
      if (v > vmax_q) v = vmax_q;
      if (v < -vmax_q) v = -vmax_q;
      th = wrap_pi(ang + fmul(v, dt_q));
      if ((th < 0 ? -th : th) > band_q) up_count = 0;
      else if (up_count < 65535) up_count++;
      ang = th;
      vel = v;
      // A half-turn difference always counts as positive.
      d = wrap_pi(th - last_ang);
      if (d == -pi_q()) d = pi_q();
      spin_sum += d;
      if (spin_sum > 64'sd2147483647) spin_sum = 64'sd2147483647;
      if (spin_sum < -64'sd2147483648) spin_sum = -64'sd2147483648;
      if (!spun && (spin_sum < 0 ? -spin_sum : spin_sum) > 5 * pi_q()) spun = 1'b1;
      if (spun && spun_steps < 65535) spun_steps++;
      last_ang = th;
      if (spin_mode != 0 && spun && spun_steps > spin_limit) term = 1'b1;
      sin_cos(th, s, c);
      reward = (spin_mode != 0 && spun) ? -ONE : c;
    end
    r.angle = ang[18:0];
    r.velocity = vel[24:0];
    r.reward = reward[17:0];
    r.terminal = term;
    r.upright = up_count[15:0];
    return r;
  endfunction

  task automatic queue_expected(swing_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Result side: random stalls, long hold-offs on request, and checking.
  always @(posedge clk) begin
    swing_result_t exp_r;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (out_terminal) terminal_seen++;
        if (out_angle_out !== exp_r.angle) begin
          $error("angle_out expected %0h got %0h", exp_r.angle, out_angle_out);
          fail_count++;
        end
        if (out_velocity_out !== exp_r.velocity) begin
          $error("velocity_out expected %0h got %0h", exp_r.velocity, out_velocity_out);
          fail_count++;
        end
        if (out_reward_out !== exp_r.reward) begin
          $error("reward_out expected %0h got %0h", exp_r.reward, out_reward_out);
          fail_count++;
        end
        if (out_terminal !== exp_r.terminal) begin
          $error("terminal expected %0h got %0h", exp_r.terminal, out_terminal);
          fail_count++;
        end
        if (out_upright_steps !== exp_r.upright) begin
          $error("upright_steps expected %0h got %0h", exp_r.upright, out_upright_steps);
          fail_count++;
        end
      end
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 16);
    end
  end

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(logic op, logic [1:0] act, logic signed [18:0] start);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_action_index <= act;
    in_start_angle <= start;
    do @(posedge clk); while (in_stall);
    queue_expected(predict_swing(op, act, start));
    sent_count++;
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIME_STEP:    dt_q = value & 'h1FFFF;
      REG_GRAVITY_GAIN: grav_q = value & 'hFFFFFF;
      REG_TORQUE_MAX:   torque_q = value & 'hFFFFFF;
      REG_SPEED_LIMIT:  vmax_q = value & 'hFFFFFF;
      REG_UPRIGHT_BAND: band_q = value & 'h3FFFF;
      REG_OVER_MODE:    spin_mode = value & 1;
      REG_OVER_LIMIT:   spin_limit = value & 'hFFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(OP_RESET, ACT_ZERO, 19'sd0);
    send_request(OP_STEP, ACT_NEG, 19'sd0);
    send_request(OP_RESET, ACT_ZERO, 19'sd205887);
    send_request(OP_RESET, ACT_ZERO, -19'sd205887);
    send_request(OP_RESET, ACT_ZERO, -19'sd262144);   // beyond -pi
    send_request(OP_RESET, ACT_ZERO, 19'sd262143);    // beyond +pi
    send_request(OP_STEP, ACT_POS, 19'sd0);
    send_request(OP_RESET, ACT_ZERO, 19'sd102944);    // pi/2
    send_request(OP_STEP, ACT_NEG, 19'sd0);
    send_request(OP_STEP, ACT_ZERO, -19'sd1);
    send_request(OP_STEP, ACT_POS, 19'sd0);
    send_request(OP_STEP, ACT_SPARE, 19'sd0);
    for (int k = 0; k < 8; k++) send_request(OP_STEP, ACT_POS, 19'sd0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TIME_STEP, 65536);
    write_reg(REG_GRAVITY_GAIN, 'hFFFFFF);
    write_reg(REG_TORQUE_MAX, 'hFFFFFF);
    write_reg(REG_SPEED_LIMIT, 'hFFFFFF);
    write_reg(REG_UPRIGHT_BAND, 205887);
    write_reg(REG_OVER_MODE, 1);
    write_reg(REG_OVER_LIMIT, 65535);
    send_request(OP_RESET, ACT_ZERO, 19'sd51472);
    for (int k = 0; k < 6; k++) send_request(OP_STEP, 2'($urandom_range(3)), 19'sd0);
    drain();
    write_reg(REG_TIME_STEP, 1);
    write_reg(REG_GRAVITY_GAIN, 0);
    write_reg(REG_TORQUE_MAX, 0);
    write_reg(REG_SPEED_LIMIT, 0);
    write_reg(REG_UPRIGHT_BAND, 0);
    write_reg(REG_OVER_LIMIT, 0);
    send_request(OP_RESET, ACT_ZERO, 19'sd0);
    for (int k = 0; k < 4; k++) send_request(OP_STEP, ACT_POS, 19'sd0);
    drain();
  endtask

  // Constant torque spins the pendulum well past five half-turns.
  task automatic test_over_rotation();
    write_reg(REG_TIME_STEP, 655);
    write_reg(REG_GRAVITY_GAIN, 642253);
    write_reg(REG_TORQUE_MAX, 131072);
    write_reg(REG_SPEED_LIMIT, 5147188);
    write_reg(REG_UPRIGHT_BAND, 51472);
    write_reg(REG_OVER_MODE, 1);
    write_reg(REG_OVER_LIMIT, 5);
    send_request(OP_RESET, ACT_ZERO, 19'sd102944);
    for (int k = 0; k < 45; k++) send_request(OP_STEP, ACT_POS, 19'sd0);
    send_request(OP_RESET, ACT_ZERO, -19'sd102944);
    for (int k = 0; k < 45; k++) send_request(OP_STEP, ACT_NEG, 19'sd0);
    drain();
  endtask

  task automatic test_back_pressure();
    hold_len = 400;
    send_request(OP_RESET, ACT_ZERO, 19'sd1000);
    for (int k = 0; k < 8; k++) send_request(OP_STEP, ACT_POS, 19'sd0);
    drain();
  endtask

  function automatic longint pick_value(longint lo, longint hi, longint typical);
    int r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r < 6) return typical + $urandom_range(int'(typical / 2));
    return lo + longint'($urandom) % (hi - lo + 1);
  endfunction

  task automatic test_random(int target);
    int phase_items, steps;
    logic signed [18:0] start;
    int phase = 0;
    while (sent_count < target) begin
      write_reg(REG_TIME_STEP, pick_value(1, 65536, 655));
      write_reg(REG_GRAVITY_GAIN, pick_value(0, 'hFFFFFF, 642253));
      write_reg(REG_TORQUE_MAX, pick_value(0, 'hFFFFFF, 131072));
      write_reg(REG_SPEED_LIMIT, pick_value(0, 'hFFFFFF, 5147188));
      write_reg(REG_UPRIGHT_BAND, pick_value(0, 205887, 51472));
      write_reg(REG_OVER_MODE, $urandom_range(1));
      write_reg(REG_OVER_LIMIT, pick_value(0, 65535, 10));
      calm = (phase == 3);
      phase_items = 0;
      while (phase_items < 150 && sent_count < target) begin
        if ($urandom_range(9) < 7) start = 19'($urandom_range(205887 * 2) - 205887);
        else start = 19'($urandom);
        send_request(OP_RESET, 2'($urandom), start);
        steps = $urandom_range(80, 3);
        for (int k = 0; k < steps; k++) begin
          // Mostly one sustained action so that rotations build up.
          if ($urandom_range(9) < 7) send_request(OP_STEP, ACT_POS, 19'($urandom));
          else send_request(OP_STEP, 2'($urandom_range(3)), 19'($urandom));
        end
        phase_items += steps + 1;
      end
      drain();
      calm = 1'b0;
      phase++;
    end
  endtask

  initial begin
    restore_defaults();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_over_rotation();
    test_back_pressure();
    test_random(1850);
    drain();
    repeat (60) @(posedge clk);
    $display("Sent %0d requests over resets, steps and register extremes;", sent_count);
    $display("checked %0d results, %0d of them terminal.", checked_count, terminal_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
